FILE: rtl/pdsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdsc_pkg;

	localparam int TARGET_LEN_DEF = 16;
	localparam int LEN_BYTES      = 4;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 8;

	localparam logic [7:0] KEY_RESET = 8'h5A;

	localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY        = 1'b1;

	typedef enum logic [1:0] {
		KIND_LEN,
		KIND_TARGET,
		KIND_BODY,
		KIND_LAST
	} pdsc_kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SHORT,
		ST_MISMATCH,
		ST_CHECKSUM
	} pdsc_status_t;

	// One classified byte on its way from the front to the back.
	typedef struct packed {
		pdsc_kind_t   kind;
		logic [7:0]   data;
		pdsc_status_t status;
		logic         last;
		logic [31:0]  length;
	} pdsc_item_t;

endpackage

`default_nettype wire

FILE: rtl/packet_deframer_sum_checksum_unit.sv
// Path: an accepted item is written into the queue, then moved into the output register.
// Throughput: one item per cycle unless the queue is full; the classifying counter and
// the output register each take one item a cycle; a four-entry queue absorbs output stalls.
// Reset: arst_n clears the byte count, length, running sum, queue and output valid,
// and sets decryption on with the key 0x5A.
`timescale 1ns / 1ps
`default_nettype none

module packet_deframer_sum_checksum_unit #(
	parameter int TARGET_LEN = pdsc_pkg::TARGET_LEN_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pdsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pdsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [7:0]                       s_tdata,  // byte_in
	input  wire logic                             s_tlast,  // last_byte
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [47:0]                           m_tdata,  // data_out, status, body_length
	output logic                                  m_tlast,  // frame_end
	output logic [1:0]                            m_tuser   // kind
);
	import pdsc_pkg::*;

	pdsc_item_t front_item;
	pdsc_item_t queue_item;
	logic       accept;
	logic       full;
	logic       not_empty;
	logic       pop;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	pdsc_front #(
		.TARGET_LEN(TARGET_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.byte_in  (s_tdata),
		.last_byte(s_tlast),
		.item     (front_item)
	);

	pdsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_item(front_item),
		.full     (full),
		.pop      (pop),
		.pop_item (queue_item),
		.not_empty(not_empty)
	);

	pdsc_back #(
		.TARGET_LEN(TARGET_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (queue_item),
		.item_valid(not_empty),
		.item_pop  (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

FILE: rtl/pdsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pdsc_front #(
	parameter int TARGET_LEN = pdsc_pkg::TARGET_LEN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       byte_in,
	input  wire logic             last_byte,
	output pdsc_pkg::pdsc_item_t  item
);
	import pdsc_pkg::*;

	localparam logic [31:0] LEN_END = 32'(LEN_BYTES);
	localparam logic [31:0] HDR_LEN = 32'(LEN_BYTES + TARGET_LEN);

	logic [31:0] count_q;
	logic [31:0] length_q;
	logic [7:0]  sum_q;
	logic        saturated;
	logic [31:0] total;

	assign saturated = (count_q == 32'hFFFF_FFFF);
	assign total     = count_q + 32'd1;

	always_comb begin
		item.data   = byte_in;
		item.last   = last_byte;
		item.length = length_q;
		item.status = ST_OK;
		if (last_byte) begin
			item.kind = KIND_LAST;
			if (!saturated && (count_q < HDR_LEN)) begin
				item.status = ST_SHORT;
			end else if (saturated || (length_q != total)) begin
				item.status = ST_MISMATCH;
			end else if (sum_q != byte_in) begin
				item.status = ST_CHECKSUM;
			end
		end else if (count_q < LEN_END) begin
			item.kind = KIND_LEN;
		end else if (count_q < HDR_LEN) begin
			item.kind = KIND_TARGET;
		end else begin
			item.kind = KIND_BODY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			length_q <= '0;
			sum_q    <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				sum_q <= sum_q + byte_in;
				if (!saturated) begin
					count_q <= total;
				end
				if (count_q < LEN_END) begin
					length_q <= {length_q[23:0], byte_in};
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pdsc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pdsc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  pdsc_pkg::pdsc_item_t  push_item,
	output logic                  full,
	input  wire logic             pop,
	output pdsc_pkg::pdsc_item_t  pop_item,
	output logic                  not_empty
);
	import pdsc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	pdsc_item_t         entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     fill_q;

	assign full      = (fill_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pdsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pdsc_back #(
	parameter int TARGET_LEN = pdsc_pkg::TARGET_LEN_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pdsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pdsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  pdsc_pkg::pdsc_item_t                  item,
	input  wire logic                             item_valid,
	output logic                                  item_pop,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [47:0]                           m_tdata,
	output logic                                  m_tlast,
	output logic [1:0]                            m_tuser
);
	import pdsc_pkg::*;

	localparam logic [31:0] MIN_FRAME = 32'(LEN_BYTES + TARGET_LEN + 1);

	logic        decrypt_q;
	logic [7:0]  key_q;
	logic        valid_q;
	logic [7:0]  data_q;
	logic [1:0]  status_q;
	logic [31:0] payload_len_q;
	logic        last_q;
	logic [1:0]  kind_q;
	logic [7:0]  data_d;
	logic [31:0] payload_len_d;

	assign item_pop = item_valid && (!valid_q || m_tready);

	always_comb begin
		data_d = item.data;
		if ((item.kind == KIND_BODY) && decrypt_q) begin
			data_d = item.data ^ key_q;
		end
		payload_len_d = '0;
		if (item.last && (item.status == ST_OK)) begin
			payload_len_d = item.length - MIN_FRAME;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b1;
			key_q     <= KEY_RESET;
			valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DECRYPT_ENABLE: decrypt_q <= cfg_wdata[0];
					CFG_XOR_KEY:        key_q     <= cfg_wdata[7:0];
					default:            ;
				endcase
			end
			if (item_pop) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			data_q        <= data_d;
			status_q      <= item.status;
			payload_len_q <= payload_len_d;
			last_q        <= item.last;
			kind_q        <= item.kind;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'd0, payload_len_q, status_q, data_q};
	assign m_tlast  = last_q;
	assign m_tuser  = kind_q;

endmodule

`default_nettype wire

FILE: rtl/pdsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pdsc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic [1:0]  m_tuser
);
	import pdsc_pkg::*;

	// A stalled output item holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
	else $error("output item changed while stalled");

	// The frame end marker and the last-byte kind always go together.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == KIND_LAST)))
	else $error("frame end and kind disagree");

	// Status and body length stay zero on bytes inside the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[41:8] == '0))
	else $error("status or body length set before the last byte");

	// A body length is reported only with success.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[9:8] != ST_OK) |-> (m_tdata[41:10] == '0))
	else $error("body length reported on a failed frame");

endmodule

bind packet_deframer_sum_checksum_unit pdsc_checker u_pdsc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

`default_nettype wire

FILE: tb/sv/tb_packet_deframer_sum_checksum_unit.sv
`timescale 1ns / 1ps

module tb_packet_deframer_sum_checksum_unit;
	import pdsc_pkg::*;

	localparam int HDR_BYTES       = LEN_BYTES + TARGET_LEN_DEF;
	localparam int MIN_FRAME_BYTES = HDR_BYTES + 1;
	localparam int ITEM_TARGET     = 1800;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int LONG_HOLD       = 300;

	typedef enum int {
		FAULT_NONE,
		FAULT_CHECKSUM,
		FAULT_LENGTH,
		FAULT_SHORT,
		FAULT_NOISE
	} frame_fault_t;

	typedef struct {
		pdsc_kind_t   kind;
		logic [7:0]   data;
		pdsc_status_t status;
		logic         frame_end;
		logic [31:0]  payload_len;
	} deframed_byte_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;   // byte_in
	logic                  s_tlast = 1'b0; // last_byte
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [47:0]           m_tdata;        // data_out, status, body_length
	logic                  m_tlast;        // frame_end
	logic [1:0]            m_tuser;        // kind

	// Predicted block state.
	logic        dec_en = 1'b1;
	logic [7:0]  key_reg = KEY_RESET;
	logic [31:0] byte_cnt = '0;
	logic [31:0] len_field = '0;
	logic [7:0]  sum_acc = '0;

	deframed_byte_t expected_bytes[$];
	int errors = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	int config_settings = 0;
	int cycle_count = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	bit hold_req = 1'b0;
	int stall_left = 0;

	packet_deframer_sum_checksum_unit #(
		.TARGET_LEN(TARGET_LEN_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic deframed_byte_t deframe_byte(input logic [7:0] b, input logic last);
		deframed_byte_t r;
		logic [31:0] total;
		r.kind = KIND_BODY;
		r.data = b;
		r.status = ST_OK;
		r.frame_end = last;
		r.payload_len = '0;
		if (last) begin
			r.kind = KIND_LAST;
			total = (byte_cnt == 32'hFFFF_FFFF) ? byte_cnt : byte_cnt + 32'd1;
			if (total < MIN_FRAME_BYTES)
				r.status = ST_SHORT;
			else if (byte_cnt == 32'hFFFF_FFFF || len_field != total)
				r.status = ST_MISMATCH;
			else if (sum_acc != b)
				r.status = ST_CHECKSUM;
			else
				r.payload_len = len_field - MIN_FRAME_BYTES;
			status_seen[r.status]++;
			byte_cnt = '0;
			sum_acc = '0;
		end else begin
			if (byte_cnt < LEN_BYTES) begin
				r.kind = KIND_LEN;
				len_field = {len_field[23:0], b};
			end else if (byte_cnt < HDR_BYTES) begin
				r.kind = KIND_TARGET;
			end else if (dec_en) begin
				r.data = b ^ key_reg;
			end
			sum_acc = sum_acc + b;
			if (byte_cnt != 32'hFFFF_FFFF)
				byte_cnt++;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		deframed_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				$error("output item with nothing expected: tdata 0x%0h", m_tdata);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				check_field("kind", 32'(want.kind), 32'(m_tuser));
				check_field("data_out", 32'(want.data), 32'(m_tdata[7:0]));
				check_field("status", 32'(want.status), 32'(m_tdata[9:8]));
				check_field("frame_end", 32'(want.frame_end), 32'(m_tlast));
				check_field("body_length", want.payload_len, m_tdata[41:10]);
				check_field("tdata_pad", 32'd0, 32'(m_tdata[47:42]));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req) begin
			stall_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (rx_idle_en && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		expected_bytes.push_back(deframe_byte(b, last));
		bytes_sent++;
	endtask

	task automatic send_frame(input int body_n, input frame_fault_t fault);
		logic [7:0] fb[$];
		logic [31:0] total;
		logic [31:0] len_val;
		logic [7:0] sum;
		int keep;
		total = HDR_BYTES + body_n + 1;
		len_val = total;
		if (fault == FAULT_LENGTH) begin
			case ($urandom_range(0, 2))
				0: len_val = total - 1;
				1: len_val = total + 1;
				default: len_val = $urandom;
			endcase
			if (len_val == total)
				len_val = ~total;
		end
		fb = '{len_val[31:24], len_val[23:16], len_val[15:8], len_val[7:0]};
		repeat (TARGET_LEN_DEF + body_n) fb.push_back(8'($urandom_range(0, 255)));
		sum = '0;
		foreach (fb[i])
			sum = sum + fb[i];
		if (fault == FAULT_CHECKSUM)
			sum = sum + 8'($urandom_range(1, 255));
		fb.push_back(sum);
		if (fault == FAULT_SHORT) begin
			keep = $urandom_range(1, MIN_FRAME_BYTES - 1);
			fb = fb[0:keep-1];
		end else if (fault == FAULT_NOISE) begin
			keep = $urandom_range(1, 30);
			fb.delete();
			repeat (keep) fb.push_back(8'($urandom_range(0, 255)));
		end
		foreach (fb[i])
			send_byte(fb[i], i == fb.size() - 1);
		frames_sent++;
	endtask

	task automatic send_random_frame();
		int r;
		int body_n;
		frame_fault_t fault;
		r = $urandom_range(0, 99);
		if (r < 65)
			fault = FAULT_NONE;
		else if (r < 75)
			fault = FAULT_CHECKSUM;
		else if (r < 85)
			fault = FAULT_LENGTH;
		else if (r < 93)
			fault = FAULT_SHORT;
		else
			fault = FAULT_NOISE;
		body_n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
		send_frame(body_n, fault);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic en, input logic [7:0] key);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DECRYPT_ENABLE;
		cfg_wdata <= {7'($urandom), en};
		@(posedge clk);
		cfg_index <= CFG_XOR_KEY;
		cfg_wdata <= key;
		@(posedge clk);
		cfg_we <= 1'b0;
		dec_en = en;
		key_reg = key;
		config_settings++;
	endtask

	task automatic test_directed();
		logic [7:0] fb[$];
		logic [7:0] sum;
		fb = '{8'h00, 8'h00, 8'h00, 8'd23,
			8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE,
			8'h10, 8'h20, 8'h30, 8'h40, 8'hC3, 8'h3C, 8'h55, 8'hAA,
			8'h00, 8'hFF};
		sum = '0;
		foreach (fb[i])
			sum = sum + fb[i];
		foreach (fb[i])
			send_byte(fb[i], 1'b0);
		send_byte(sum, 1'b1);
		send_byte(8'hFF, 1'b1);
		frames_sent += 2;
		wait_idle();
	endtask

	task automatic test_config_sweep();
		logic en_list[5];
		logic [7:0] key_list[5];
		int phase_end;
		en_list = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		key_list = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'($urandom)};
		for (int p = 0; p < 5; p++) begin
			set_config(en_list[p], key_list[p]);
			rx_idle_en = (p != 2);
			tx_idle_en = (p != 3);
			phase_end = bytes_sent + 200;
			while (bytes_sent < phase_end)
				send_random_frame();
			wait_idle();
		end
		rx_idle_en = 1'b1;
		tx_idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		int phase_end;
		set_config(1'b1, 8'($urandom));
		tx_idle_en = 1'b0;
		hold_req = 1'b1;
		phase_end = bytes_sent + 150;
		while (bytes_sent < phase_end)
			send_random_frame();
		tx_idle_en = 1'b1;
		wait_idle();
	endtask

	task automatic test_random_frames();
		set_config(1'($urandom), 8'($urandom));
		while (bytes_sent < ITEM_TARGET)
			send_random_frame();
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random_frames();
		repeat (10) @(posedge clk);
		$display("Sent %0d items in %0d frames under %0d register settings.",
			bytes_sent, frames_sent, config_settings);
		$display("Frame results: %0d good, %0d too short, %0d length mismatch, %0d bad checksum.",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_MISMATCH],
			status_seen[ST_CHECKSUM]);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
